>>> hdl/sprite_animation_sequencer_assert.svh
// assertion macros shared by the sprite animation sequencer modules
`ifndef SPRITE_ANIMATION_SEQUENCER_ASSERT_SVH
`define SPRITE_ANIMATION_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SAS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sequencer assertion failed");

// next-cycle implication, checked out of reset
`define SAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");

`endif

>>> hdl/sas_pkg.sv
// types, constants and request codes of the sprite animation sequencer
package sas_pkg;

    localparam int NUM_STATES  = 16;
    localparam int NUM_TRANS   = 32;
    localparam int STATE_W     = 4;
    localparam int SLOT_W      = 5;
    localparam int FRAME_BITS  = 16;
    localparam int TIME_BITS   = 24;
    localparam int DELTA_W     = 16;
    localparam int FRAC_W      = 17;
    localparam int FRAC_SHIFT  = 16;
    localparam int COUNT_W     = FRAME_BITS + 1;
    localparam int PROD_W      = TIME_BITS + COUNT_W;
    localparam int SCAN_W      = SLOT_W + 1;

    // request codes
    localparam logic [2:0] REQ_TICK       = 3'd0;
    localparam logic [2:0] REQ_LOAD_STATE = 3'd1;
    localparam logic [2:0] REQ_LOAD_TRANS = 3'd2;
    localparam logic [2:0] REQ_SET_STATE  = 3'd3;
    localparam logic [2:0] REQ_SET_INIT   = 3'd4;
    localparam logic [2:0] REQ_PLAY       = 3'd5;
    localparam logic [2:0] REQ_STOP       = 3'd6;
    // spare code, takes no action
    localparam logic [2:0] REQ_UNUSED     = 3'd7;

    typedef struct packed {
        logic [2:0]            req_type;
        logic [SLOT_W-1:0]     slot_index;
        logic [DELTA_W-1:0]    delta_time;
        logic [FRAME_BITS-1:0] start_frame;
        logic [FRAME_BITS-1:0] end_frame;
        logic [TIME_BITS-1:0]  clip_duration;
        logic                  loop_flag;
        logic [STATE_W-1:0]    from_state;
        logic [STATE_W-1:0]    target_state;
        logic [FRAC_W-1:0]     exit_fraction;
    } t_in_word;

    typedef struct packed {
        logic [STATE_W-1:0]    current_state;
        logic                  has_state;
        logic [FRAME_BITS-1:0] frame_number;
        logic                  playing;
        logic                  entered;
        logic [TIME_BITS-1:0]  elapsed;
        logic                  accepted;
    } t_out_word;

    typedef struct packed {
        logic [FRAME_BITS-1:0] first;
        logic [FRAME_BITS-1:0] last;
        logic [TIME_BITS-1:0]  length;
        logic                  repeat_en;
    } t_clip;

    typedef struct packed {
        logic [STATE_W-1:0] src;
        logic [STATE_W-1:0] dst;
        logic [FRAC_W-1:0]  frac;
    } t_trans;

    // frame divider request and response
    typedef struct packed {
        logic                 start;
        logic [TIME_BITS-1:0] t;
        logic [COUNT_W-1:0]   count;
        logic [TIME_BITS-1:0] length;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> hdl/sas_ram.sv
// generic single-write, single-read ram with registered read data
module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

>>> hdl/sas_div.sv
// frame index unit: floor(t * count / length), one quotient bit per cycle
`include "sprite_animation_sequencer_assert.svh"
module sas_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sas_pkg::t_div_req i_req,
    output sas_pkg::t_div_rsp o_rsp
);

    localparam int PW = sas_pkg::PROD_W;
    localparam int TW = sas_pkg::TIME_BITS;
    localparam int CW = sas_pkg::COUNT_W;
    localparam int NW = $clog2(PW + 1);

    logic          r_busy;
    logic [NW-1:0] r_cnt;
    logic [PW-1:0] r_dvd;
    logic [TW-1:0] r_rem;
    logic [TW-1:0] r_len;
    logic [CW-1:0] r_quot;
    logic [TW:0]   trial;
    logic          q_bit;

    // restoring step
    always_comb begin
        trial = {r_rem, r_dvd[PW-1]};
        q_bit = (trial >= {1'b0, r_len});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= NW'(PW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != NW'(1));
        end
    end

    // datapath, product registered before the first step
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd  <= PW'(i_req.t) * PW'(i_req.count);
            r_len  <= i_req.length;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[PW-2:0], 1'b0};
            r_rem  <= q_bit ? TW'(trial - {1'b0, r_len}) : trial[TW-1:0];
            r_quot <= {r_quot[CW-2:0], q_bit};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_quot;

    `SAS_ASSERT_NOW(a_no_restart, i_req.start, !r_busy)
    `SAS_ASSERT_NEXT(a_step_count, r_busy && r_cnt == NW'(1), !r_busy)
    `SAS_ASSERT_NOW(a_rem_below_len, r_busy, r_rem < r_len)

endmodule

>>> hdl/sprite_animation_sequencer.sv
// sprite animation sequencer top level: clip and transition tables, tick engine
// One request word in, one result word out. Loads, set, play, stop and ticks
// taken while stopped or without a state commit their result straight from
// idle. A tick that advances time reads the active clip from its table ram,
// then runs the frame index divider (one quotient bit per cycle) while the
// transition table is scanned one slot per cycle, and commits its result once
// both are done and the result register is free; only then does it return to
// idle and take the next request, so no new request is taken during a tick.
// A new request is taken while the previous result still waits on the output,
// as long as the result register frees in that cycle or is already empty.
// Tables need no clearing after reset.
`include "sprite_animation_sequencer_assert.svh"
module sprite_animation_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sas_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sas_pkg::t_out_word o_out_word
);

    localparam int SW = sas_pkg::STATE_W;
    localparam int FB = sas_pkg::FRAME_BITS;
    localparam int TB = sas_pkg::TIME_BITS;
    localparam int CW = sas_pkg::COUNT_W;
    localparam int PW = sas_pkg::PROD_W;
    localparam int KW = sas_pkg::SCAN_W;
    localparam int LW = sas_pkg::SLOT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_CLIP, ST_RUN} t_state;

    t_state                 r_state, n_state;
    logic [SW-1:0]          r_active, n_active;
    logic                   r_active_valid, n_active_valid;
    logic [TB-1:0]          r_time, n_time;
    logic [FB-1:0]          r_frame, n_frame;
    logic                   r_run, n_run;
    logic                   r_entry, n_entry;
    logic [sas_pkg::NUM_STATES-1:0] r_clip_valid, n_clip_valid;
    logic [sas_pkg::NUM_TRANS-1:0]  r_trans_valid, n_trans_valid;
    logic                   r_out_valid, n_out_valid;
    sas_pkg::t_out_word     r_out_word, n_out_word;
    logic [sas_pkg::DELTA_W-1:0] r_dt;
    logic [TB-1:0]          r_ntime;
    sas_pkg::t_clip         r_clip;
    logic                   r_at_end;

    // scan pipeline
    logic [KW-1:0]          r_scan_addr;
    logic                   r_p1_valid;
    logic [LW-1:0]          r_p1_idx;
    logic                   r_p2_valid;
    logic [PW-1:0]          r_p2_prod;
    logic [SW-1:0]          r_p2_dst;
    logic                   r_hit;
    logic [SW-1:0]          r_hit_dst;

    logic                   in_acc, out_free, commit, scan_issue, scan_done, hit_now;
    logic                   clip_wr_en, clip_rd_en, trans_wr_en, load_clip;
    sas_pkg::t_clip         clip_wr, clip_rd;
    sas_pkg::t_trans        trans_wr, trans_rd;
    sas_pkg::t_div_req      div_req;
    sas_pkg::t_div_rsp      div_rsp;
    logic [TB:0]            sum;
    logic [TB-1:0]          sat;
    logic [CW-1:0]          count, idx;
    logic                   res_ok;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    // table memories
    assign clip_wr.first     = i_in_word.start_frame;
    assign clip_wr.last      = i_in_word.end_frame;
    assign clip_wr.length    = i_in_word.clip_duration;
    assign clip_wr.repeat_en = i_in_word.loop_flag;
    assign trans_wr.src      = i_in_word.from_state;
    assign trans_wr.dst      = i_in_word.target_state;
    assign trans_wr.frac     = i_in_word.exit_fraction;

    sas_ram #(.WIDTH($bits(sas_pkg::t_clip)), .DEPTH(sas_pkg::NUM_STATES)) u_clip_ram (
        .i_clk     (i_clk),
        .i_wr_en   (clip_wr_en),
        .i_wr_addr (i_in_word.slot_index[SW-1:0]),
        .i_wr_data (clip_wr),
        .i_rd_en   (clip_rd_en),
        .i_rd_addr (r_active),
        .o_rd_data (clip_rd)
    );

    sas_ram #(.WIDTH($bits(sas_pkg::t_trans)), .DEPTH(sas_pkg::NUM_TRANS)) u_trans_ram (
        .i_clk     (i_clk),
        .i_wr_en   (trans_wr_en),
        .i_wr_addr (i_in_word.slot_index),
        .i_wr_data (trans_wr),
        .i_rd_en   (scan_issue),
        .i_rd_addr (r_scan_addr[LW-1:0]),
        .o_rd_data (trans_rd)
    );

    // new time from the clip just read
    always_comb begin
        sum = {1'b0, r_time} + (TB+1)'(r_dt);
        sat = sum[TB] ? '1 : sum[TB-1:0];
        if (sat >= clip_rd.length) begin
            sat = clip_rd.repeat_en ? '0 : clip_rd.length;
        end
    end

    // frame divider
    assign div_req.start  = (r_state == ST_CLIP);
    assign div_req.t      = sat;
    assign div_req.count  = CW'(clip_rd.last) - CW'(clip_rd.first) + CW'(1);
    assign div_req.length = clip_rd.length;

    sas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // transition scan, in slot order, first hit wins
    assign scan_issue = (r_state == ST_RUN) && !r_hit &&
                        (r_scan_addr != KW'(sas_pkg::NUM_TRANS));
    assign hit_now    = r_p2_valid && !r_hit &&
                        ({1'b0, r_ntime, {sas_pkg::FRAC_SHIFT{1'b0}}} >= r_p2_prod);
    assign scan_done  = r_hit || (!scan_issue && !r_p1_valid && !r_p2_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_hit       <= 1'b0;
        end else if (r_state == ST_CLIP) begin
            r_scan_addr <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_scan_addr <= scan_issue ? r_scan_addr + 1'b1 : r_scan_addr;
            r_p1_valid  <= scan_issue;
            r_p1_idx    <= r_scan_addr[LW-1:0];
            r_p2_valid  <= r_p1_valid && r_trans_valid[r_p1_idx] && (trans_rd.src == r_active);
            r_p2_prod   <= PW'(trans_rd.frac) * PW'(r_clip.length);
            r_p2_dst    <= trans_rd.dst;
            if (hit_now) begin
                r_hit     <= 1'b1;
                r_hit_dst <= r_p2_dst;
            end
        end
    end

    // frame from the divider result
    always_comb begin
        count = CW'(r_clip.last) - CW'(r_clip.first) + CW'(1);
        idx   = (div_rsp.quot >= count) ? count - CW'(1) : div_rsp.quot;
    end

    // request sequencing and state update
    always_comb begin
        n_state        = r_state;
        n_active       = r_active;
        n_active_valid = r_active_valid;
        n_time         = r_time;
        n_frame        = r_frame;
        n_run          = r_run;
        n_entry        = r_entry;
        n_clip_valid   = r_clip_valid;
        n_trans_valid  = r_trans_valid;
        n_out_valid    = r_out_valid;
        n_out_word     = r_out_word;
        clip_wr_en     = 1'b0;
        trans_wr_en    = 1'b0;
        clip_rd_en     = 1'b0;
        commit         = 1'b0;
        res_ok         = 1'b1;
        load_clip      = (i_in_word.slot_index < LW'(sas_pkg::NUM_STATES)) &&
                         (i_in_word.clip_duration != '0);
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_entry = 1'b0;
                    commit  = 1'b1;
                    unique case (i_in_word.req_type)
                        sas_pkg::REQ_TICK: begin
                            if (r_run && r_active_valid) begin
                                clip_rd_en = 1'b1;
                                commit     = 1'b0;
                                n_state    = ST_CLIP;
                            end
                        end
                        sas_pkg::REQ_LOAD_STATE: begin
                            res_ok = load_clip;
                            if (load_clip) begin
                                clip_wr_en = 1'b1;
                                n_clip_valid[i_in_word.slot_index[SW-1:0]] = 1'b1;
                            end
                        end
                        sas_pkg::REQ_LOAD_TRANS: begin
                            trans_wr_en = 1'b1;
                            n_trans_valid[i_in_word.slot_index] = 1'b1;
                        end
                        sas_pkg::REQ_SET_STATE, sas_pkg::REQ_SET_INIT: begin
                            res_ok = (i_in_word.slot_index < LW'(sas_pkg::NUM_STATES)) &&
                                     r_clip_valid[i_in_word.slot_index[SW-1:0]];
                            if (res_ok) begin
                                n_active       = i_in_word.slot_index[SW-1:0];
                                n_active_valid = 1'b1;
                                n_time         = '0;
                                n_frame        = '0;
                                n_entry        = 1'b1;
                            end
                        end
                        sas_pkg::REQ_PLAY: n_run = 1'b1;
                        sas_pkg::REQ_STOP: n_run = 1'b0;
                        default: ;
                    endcase
                end
            end
            ST_CLIP: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (scan_done && !div_rsp.busy && out_free) begin
                    commit  = 1'b1;
                    n_state = ST_IDLE;
                    n_time  = r_ntime;
                    n_frame = (r_clip.last < r_clip.first) ? r_clip.first
                                                           : FB'(CW'(r_clip.first) + idx);
                    if (r_hit) begin
                        if (r_clip_valid[r_hit_dst]) begin
                            n_active = r_hit_dst;
                            n_time   = '0;
                            n_frame  = '0;
                            n_entry  = 1'b1;
                        end
                    end else if (r_at_end) begin
                        n_run = 1'b0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // result register
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (commit) begin
            n_out_valid                = 1'b1;
            n_out_word.current_state   = n_active;
            n_out_word.has_state       = n_active_valid;
            n_out_word.frame_number    = n_frame;
            n_out_word.playing         = n_run;
            n_out_word.entered         = n_entry;
            n_out_word.elapsed         = n_time;
            n_out_word.accepted        = res_ok;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_active       <= '0;
            r_active_valid <= 1'b0;
            r_time         <= '0;
            r_frame        <= '0;
            r_run          <= 1'b0;
            r_entry        <= 1'b0;
            r_clip_valid   <= '0;
            r_trans_valid  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_active       <= n_active;
            r_active_valid <= n_active_valid;
            r_time         <= n_time;
            r_frame        <= n_frame;
            r_run          <= n_run;
            r_entry        <= n_entry;
            r_clip_valid   <= n_clip_valid;
            r_trans_valid  <= n_trans_valid;
            r_out_valid    <= n_out_valid;
        end
        r_out_word <= n_out_word;
        if (in_acc) begin
            r_dt <= i_in_word.delta_time;
        end
        if (r_state == ST_CLIP) begin
            r_clip   <= clip_rd;
            r_ntime  <= sat;
            r_at_end <= !clip_rd.repeat_en && (sat >= clip_rd.length);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `SAS_ASSERT_NEXT(a_has_state_sticky, r_active_valid, r_active_valid)
    `SAS_ASSERT_NOW(a_active_loaded, r_active_valid, r_clip_valid[r_active])
    `SAS_ASSERT_NOW(a_tick_needs_run, r_state == ST_CLIP, r_run && r_active_valid)

endmodule

>>> sim/sprite_animation_sequencer_tb.sv
// self-checking testbench for the sprite animation sequencer
`timescale 1ns / 100ps
module sprite_animation_sequencer_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 100;
    localparam int STALL_CYCLES = 400;
    localparam int N_WORDS = 1500;
    localparam int IN_W = $bits(sas_pkg::t_in_word);

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    sas_pkg::t_in_word  i_in_word;
    logic               o_out_valid;
    logic               i_out_ready;
    sas_pkg::t_out_word o_out_word;

    sprite_animation_sequencer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    // predictor copy of the sequencer state
    sas_pkg::t_clip                 clips[sas_pkg::NUM_STATES];
    logic                           clip_ok[sas_pkg::NUM_STATES] = '{default: 1'b0};
    sas_pkg::t_trans                trans[sas_pkg::NUM_TRANS];
    logic                           trans_ok[sas_pkg::NUM_TRANS] = '{default: 1'b0};
    logic [sas_pkg::STATE_W-1:0]    cur_state = '0;
    logic                           cur_valid = 1'b0;
    logic [sas_pkg::TIME_BITS-1:0]  cur_time = '0;
    logic [sas_pkg::FRAME_BITS-1:0] cur_frame = '0;
    logic                           run_on = 1'b0;
    logic                           entry_on = 1'b0;

    sas_pkg::t_in_word  pending_words[$];
    sas_pkg::t_out_word expected_words[$];
    int        mismatches = 0;
    int        unexpected = 0;
    int        words_sent = 0;
    int        words_checked = 0;
    int        cycle_count = 0;
    int        in_wait;
    int        out_wait;
    int        stall_left;
    logic      stall_request;
    logic      stall_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // queue helpers
    function automatic void add_request(input sas_pkg::t_in_word w);
        pending_words = {pending_words, w};
    endfunction

    function automatic void add_expected(input sas_pkg::t_out_word r);
        expected_words = {expected_words, r};
    endfunction

    function automatic logic enter_clip(input int s);
        if (s >= sas_pkg::NUM_STATES || !clip_ok[s]) return 1'b0;
        cur_state = s[sas_pkg::STATE_W-1:0];
        cur_valid = 1'b1;
        cur_time  = '0;
        cur_frame = '0;
        entry_on  = 1'b1;
        return 1'b1;
    endfunction

    // advance time on a tick and follow transitions
    function automatic void advance_time(input logic [sas_pkg::DELTA_W-1:0] dt);
        sas_pkg::t_clip c;
        logic [63:0]    t;
        logic [63:0]    cnt;
        logic [63:0]    idx;
        logic           hit;
        if (!run_on || !cur_valid || !clip_ok[cur_state]) return;
        c   = clips[cur_state];
        hit = 1'b0;
        t   = 64'(cur_time) + 64'(dt);
        if (t > 64'hFF_FFFF) t = 64'hFF_FFFF;
        if (t >= 64'(c.length)) t = c.repeat_en ? 64'd0 : 64'(c.length);
        cur_time = t[sas_pkg::TIME_BITS-1:0];
        // frame index, clamped to the clip
        if (c.last < c.first) begin
            cur_frame = c.first;
        end else begin
            cnt = 64'(c.last) - 64'(c.first) + 64'd1;
            idx = (t * cnt) / 64'(c.length);
            if (idx >= cnt) idx = cnt - 1;
            cur_frame = c.first + idx[sas_pkg::FRAME_BITS-1:0];
        end
        entry_on = 1'b0;
        for (int i = 0; i < sas_pkg::NUM_TRANS; i++) begin
            if (!hit && trans_ok[i] && trans[i].src == cur_state &&
                (t << 16) >= 64'(trans[i].frac) * 64'(c.length)) begin
                void'(enter_clip(int'(trans[i].dst)));
                hit = 1'b1;
            end
        end
        if (!hit && !c.repeat_en && t >= 64'(c.length)) run_on = 1'b0;
    endfunction

    function automatic sas_pkg::t_out_word predict_word(input sas_pkg::t_in_word w);
        sas_pkg::t_out_word r;
        logic               ok;
        ok       = 1'b1;
        entry_on = 1'b0;
        case (w.req_type)
            sas_pkg::REQ_TICK: advance_time(w.delta_time);
            sas_pkg::REQ_LOAD_STATE: begin
                if (w.slot_index >= sas_pkg::NUM_STATES || w.clip_duration == 0) begin
                    ok = 1'b0;
                end else begin
                    clip_ok[w.slot_index] = 1'b1;
                    clips[w.slot_index] = '{first: w.start_frame, last: w.end_frame,
                        length: w.clip_duration, repeat_en: w.loop_flag};
                end
            end
            sas_pkg::REQ_LOAD_TRANS: begin
                trans_ok[w.slot_index] = 1'b1;
                trans[w.slot_index] = '{src: w.from_state, dst: w.target_state,
                    frac: w.exit_fraction};
            end
            sas_pkg::REQ_SET_STATE, sas_pkg::REQ_SET_INIT:
                ok = enter_clip(int'(w.slot_index));
            sas_pkg::REQ_PLAY: run_on = 1'b1;
            sas_pkg::REQ_STOP: run_on = 1'b0;
            default: ;
        endcase
        r.current_state = cur_state;
        r.has_state     = cur_valid;
        r.frame_number  = cur_frame;
        r.playing       = run_on;
        r.entered       = entry_on;
        r.elapsed       = cur_time;
        r.accepted      = ok;
        return r;
    endfunction

    function automatic sas_pkg::t_in_word make_word(input logic [2:0] req, input int slot);
        sas_pkg::t_in_word w;
        w = sas_pkg::t_in_word'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
        w.req_type   = req;
        w.slot_index = slot[sas_pkg::SLOT_W-1:0];
        return w;
    endfunction

    function automatic sas_pkg::t_in_word clip_word(input int slot, input int first,
                                                    input int span, input int len,
                                                    input logic rep);
        sas_pkg::t_in_word w;
        w = make_word(sas_pkg::REQ_LOAD_STATE, slot);
        w.start_frame   = first[15:0];
        w.end_frame     = first[15:0] + span[15:0];
        w.clip_duration = len[23:0];
        w.loop_flag     = rep;
        return w;
    endfunction

    function automatic sas_pkg::t_in_word trans_word(input int slot, input int src,
                                                     input int dst, input int frac);
        sas_pkg::t_in_word w;
        w = make_word(sas_pkg::REQ_LOAD_TRANS, slot);
        w.from_state    = src[3:0];
        w.target_state  = dst[3:0];
        w.exit_fraction = frac[16:0];
        return w;
    endfunction

    function automatic sas_pkg::t_in_word tick_word(input int dt);
        sas_pkg::t_in_word w;
        w = make_word(sas_pkg::REQ_TICK, 0);
        w.delta_time = dt[15:0];
        return w;
    endfunction

    // stimulus: directed corners, then random animation sessions
    initial begin
        sas_pkg::t_in_word w;
        int                n;

        add_request(tick_word(5));
        add_request(make_word(sas_pkg::REQ_PLAY, 0));
        add_request(tick_word(100));
        add_request(make_word(sas_pkg::REQ_SET_STATE, 3));
        add_request(clip_word(31, 0, 3, 10, 1'b0));
        add_request(clip_word(2, 0, 3, 0, 1'b0));
        add_request(clip_word(0, 65535, 0, 16777215, 1'b1));
        add_request(clip_word(1, 10, 9, 100, 1'b0));
        w = clip_word(2, 500, 0, 50, 1'b1);
        w.end_frame = 16'd20;
        add_request(w);
        add_request(clip_word(15, 0, 65535, 1, 1'b0));
        add_request(trans_word(31, 1, 9, 65536));
        add_request(trans_word(0, 2, 15, 131071));
        add_request(trans_word(1, 1, 2, 0));
        add_request(make_word(sas_pkg::REQ_UNUSED, 0));
        add_request(make_word(sas_pkg::REQ_SET_INIT, 1));
        add_request(make_word(sas_pkg::REQ_PLAY, 0));
        add_request(tick_word(65535));
        add_request(tick_word(0));
        add_request(make_word(sas_pkg::REQ_SET_STATE, 0));
        add_request(tick_word(65535));
        add_request(make_word(sas_pkg::REQ_STOP, 0));
        add_request(tick_word(7));
        add_request(make_word(sas_pkg::REQ_SET_STATE, 15));
        add_request(make_word(sas_pkg::REQ_PLAY, 0));
        add_request(tick_word(3));

        n = pending_words.size();
        while (n < N_WORDS) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    // mostly short clips so ends and loops happen often
                    w = clip_word($urandom_range(0, 15), $urandom_range(0, 65535),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 12),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16777215)
                                                    : $urandom_range(1, 400),
                        1'($urandom));
                    if ($urandom_range(0, 15) == 0) w.end_frame = w.start_frame - 16'd1;
                    if ($urandom_range(0, 30) == 0) w.clip_duration = '0;
                    if ($urandom_range(0, 30) == 0) w.slot_index = 5'($urandom_range(16, 31));
                end
                2: w = trans_word($urandom_range(0, 31), $urandom_range(0, 15),
                        $urandom_range(0, 15),
                        ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071)
                                                    : $urandom_range(0, 65536));
                3: w = make_word($urandom_range(0, 1) ? sas_pkg::REQ_SET_STATE
                                                      : sas_pkg::REQ_SET_INIT,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(16, 31)
                                                    : $urandom_range(0, 15));
                4: w = make_word($urandom_range(0, 3) ? sas_pkg::REQ_PLAY
                                                      : sas_pkg::REQ_STOP, 0);
                5: w = make_word(sas_pkg::REQ_UNUSED, $urandom_range(0, 31));
                default: w = tick_word(($urandom_range(0, 19) == 0) ?
                        $urandom_range(0, 65535) : $urandom_range(0, 120));
            endcase
            add_request(w);
            n++;
        end
    end

    // reset, long receiver hold-off, end of run
    initial begin
        stall_request = 1'b0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (words_sent >= 300);
        stall_request = 1'b1;
        wait (stall_done);
        wait (words_sent >= N_WORDS && words_checked >= words_sent);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d request words, checked %0d results, including a %0d-cycle",
                 words_sent, words_checked, STALL_CYCLES);
        $display("output stall, table loads, state switches, loops and one-shot ends");
        if (mismatches == 0 && unexpected == 0 && expected_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("mismatches %0d, unexpected %0d, left %0d",
                     mismatches, unexpected, expected_words.size());
            $display("Test completed with failures");
        end
        $finish;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // driver: presents words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_word  <= '0;
            in_wait    <= $urandom_range(0, 8);
        end else if (i_in_valid && o_in_ready) begin
            add_expected(predict_word(i_in_word));
            words_sent <= words_sent + 1;
            in_wait    <= $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0;
            if (in_wait == 0 && pending_words.size() > 0 && $urandom_range(0, 3) != 0) begin
                i_in_word <= pending_words.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid) begin
            if (in_wait > 0) begin
                in_wait <= in_wait - 1;
            end else if (pending_words.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_word  <= pending_words.pop_front();
            end
        end
    end

    // monitor: checks results, stalls at random and once for a long stretch
    always @(posedge i_clk) begin
        sas_pkg::t_out_word exp_w;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_wait    <= 0;
            stall_left  <= 0;
            stall_done  <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    unexpected <= unexpected + 1;
                    $display("unexpected result word %h", o_out_word);
                end else begin
                    exp_w = expected_words.pop_front();
                    if (o_out_word !== exp_w) begin
                        if (mismatches < 10)
                            $display("mismatch at result %0d: expected %p actual %p",
                                     words_checked, exp_w, o_out_word);
                        mismatches <= mismatches + 1;
                    end
                end
                words_checked <= words_checked + 1;
                out_wait <= $urandom_range(0, 2) == 0 ? $urandom_range(1, 8) : 0;
            end
            if (stall_request && !stall_done && stall_left == 0) begin
                stall_left  <= STALL_CYCLES;
                stall_done  <= 1'b1;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left  <= stall_left - 1;
                i_out_ready <= 1'b0;
            end else if (o_out_valid && i_out_ready) begin
                i_out_ready <= ($urandom_range(0, 2) != 0);
            end else if (out_wait > 0) begin
                out_wait    <= out_wait - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

endmodule
